[rtl/clst_pkg.sv]
// Shared definitions for the compacting list store: operation codes,
// fixed field widths and the control bundle sent to every list cell.
// No dependencies.
`timescale 1ns / 1ps

package clst_pkg;

   // Operation codes carried on the func field.
   localparam int FUNC_W = 3;
   localparam logic [FUNC_W-1:0] FUNC_APPEND       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_SET   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_RANGE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ         = 3'd4;

   // Fixed widths of the beat fields.
   localparam int INDEX_W     = 4;
   localparam int MASK_W      = 16;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 5;

   // Number of list positions that an index or a mask bit can name.
   localparam int REACH = 16;

   // Per-cycle command broadcast to the chain of cells.
   typedef struct packed {
      logic mark;     // load the removal marks of the new operation
      logic shift;    // one compaction step: cells from the lowest mark on pull from the right
      logic append;   // write the append value into the cell at the tail
   } cell_ctl_type;

endpackage

[rtl/compacting_list_store_core.sv]
// Top level of the compacting list store: operation decode, count and
// result register around a chain of clst_cell instances.
// Depends on clst_pkg and clst_cell.
`timescale 1ns / 1ps

// An ordered, packed list of up to DEPTH entries held in a chain of cells.
// Each request beat carries one operation (append, remove at an index,
// remove the positions set in a mask, remove an inclusive range, or read)
// and yields exactly one response beat with the success flag, the count
// held afterwards and, for a successful read, the entry. The cells close
// the gaps one position per cycle, each step pulling every entry right
// of the lowest marked position one place left. Indexes and the mask
// reach positions 0 to 15 only. A new request is taken once the
// previous operation has settled, even while its response still waits
// in the output register.
module compacting_list_store_core #(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [clst_pkg::FUNC_W-1:0]        req_func,
   input  logic [clst_pkg::VALUE_W-1:0]       req_entry_value,
   input  logic [clst_pkg::INDEX_W-1:0]       req_first_index,
   input  logic [clst_pkg::INDEX_W-1:0]       req_last_index,
   input  logic [clst_pkg::MASK_W-1:0]        req_remove_mask,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic [clst_pkg::COUNT_OUT_W-1:0]   rsp_held_count,
   output logic [clst_pkg::VALUE_W-1:0]       rsp_read_value
);

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W   = clst_pkg::INDEX_W;
   localparam int CMP_W   = (COUNT_W > IDX_W + 1) ? COUNT_W : IDX_W + 1;
   localparam int REACH   = clst_pkg::REACH;
   localparam int VIEW    = (DEPTH < REACH) ? DEPTH : REACH;
   localparam int VW      = clst_pkg::VALUE_W;
   localparam int CW      = clst_pkg::COUNT_OUT_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   logic                    state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    pend_ok_ff, pend_ok_in;
   logic [VW-1:0]           pend_read_ff, pend_read_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;
   logic [VW-1:0]           rsp_value_ff, rsp_value_in;

   logic                    accept;
   logic                    finish;
   logic                    any_drop;
   logic                    full;
   logic                    first_held;
   logic [CMP_W-1:0]        count_cmp;
   logic [CMP_W-1:0]        first_cmp;
   logic [CMP_W-1:0]        last_cmp;
   logic                    op_ok;
   logic                    op_append;
   logic                    op_read;
   logic [DEPTH-1:0]        mark_vec;
   logic [ENTRY_WIDTH-1:0]  append_value;
   logic [ENTRY_WIDTH-1:0]  read_word;
   clst_pkg::cell_ctl_type  cell_ctl;

   logic [ENTRY_WIDTH-1:0]  chain_value [DEPTH+1];
   logic                    chain_drop  [DEPTH+1];
   logic                    chain_carry [DEPTH+1];
   logic [ENTRY_WIDTH-1:0]  read_view   [REACH];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   // Comparisons of indexes against the held count, in a common width.
   assign count_cmp  = CMP_W'(count_ff);
   assign first_cmp  = CMP_W'(req_first_index);
   assign last_cmp   = CMP_W'(req_last_index);
   assign first_held = (first_cmp < count_cmp);
   assign full       = (count_ff == COUNT_W'(DEPTH));

   // Decode the operation into success, removal marks and side actions.
   always_comb begin
      int p;
      mark_vec  = '0;
      op_ok     = 1'b0;
      op_append = 1'b0;
      op_read   = 1'b0;
      unique case (req_func)
         clst_pkg::FUNC_APPEND: begin
            op_ok     = !full;
            op_append = !full;
         end
         clst_pkg::FUNC_REMOVE_AT: begin
            op_ok = first_held;
            for (p = 0; p < VIEW; p++) begin
               mark_vec[p] = first_held && (first_cmp == CMP_W'(p));
            end
         end
         clst_pkg::FUNC_REMOVE_SET: begin
            for (p = 0; p < VIEW; p++) begin
               mark_vec[p] = req_remove_mask[p] && (CMP_W'(p) < count_cmp);
            end
            op_ok = |mark_vec;
         end
         clst_pkg::FUNC_REMOVE_RANGE: begin
            // An end below the start marks nothing but still succeeds.
            op_ok = first_held;
            for (p = 0; p < VIEW; p++) begin
               mark_vec[p] = first_held && (CMP_W'(p) >= first_cmp)
                             && (CMP_W'(p) <= last_cmp) && (CMP_W'(p) < count_cmp);
            end
         end
         clst_pkg::FUNC_READ: begin
            op_ok   = first_held;
            op_read = first_held;
         end
         default: begin
         end
      endcase
   end

   // Read port over the positions an index can reach.
   for (genvar v = 0; v < REACH; v++) begin : g_view
      if (v < DEPTH) begin : g_held
         assign read_view[v] = chain_value[v];
      end else begin : g_none
         assign read_view[v] = '0;
      end
   end
   assign read_word    = read_view[req_first_index];
   assign append_value = ENTRY_WIDTH'(req_entry_value);

   // Command to the cells.
   assign cell_ctl.mark   = accept;
   assign cell_ctl.shift  = (state_ff == S_WORK) && any_drop;
   assign cell_ctl.append = accept && op_append;

   // The chain of cells; the right end feeds an empty, unmarked slot.
   assign chain_value[DEPTH] = '0;
   assign chain_drop[DEPTH]  = 1'b0;
   assign chain_carry[0]     = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      clst_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .mark         (mark_vec[i]),
         .append_hit   (count_ff == COUNT_W'(i)),
         .append_value (append_value),
         .next_value   (chain_value[i+1]),
         .next_drop    (chain_drop[i+1]),
         .carry_in     (chain_carry[i]),
         .value        (chain_value[i]),
         .drop         (chain_drop[i]),
         .carry_out    (chain_carry[i+1])
      );
   end

   assign any_drop = chain_carry[DEPTH];

   // The operation is done once no mark remains and the output slot is free.
   assign finish = (state_ff == S_WORK) && !any_drop && (!rsp_valid_ff || rsp_ready);

   // Sequencer and held count.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WORK;
               if (op_append) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
         end
         S_WORK: begin
            if (any_drop) begin
               count_in = count_ff - COUNT_W'(1);
            end else if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result of the operation in flight, captured at acceptance.
   assign pend_ok_in   = accept ? op_ok : pend_ok_ff;
   assign pend_read_in = accept ? (op_read ? VW'(read_word) : '0) : pend_read_ff;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      rsp_value_in = rsp_value_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = pend_ok_ff;
         rsp_count_in = CW'(count_ff);
         rsp_value_in = pend_read_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ok_ff   <= pend_ok_in;
      pend_read_ff <= pend_read_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_held_count = rsp_count_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

[rtl/clst_cell.sv]
// One list position: an entry register and its removal mark.
// Depends on clst_pkg for the cell control bundle.
`timescale 1ns / 1ps

module clst_cell #(
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  clst_pkg::cell_ctl_type   ctl,
   input  logic                     mark,
   input  logic                     append_hit,
   input  logic [ENTRY_WIDTH-1:0]   append_value,
   input  logic [ENTRY_WIDTH-1:0]   next_value,
   input  logic                     next_drop,
   input  logic                     carry_in,
   output logic [ENTRY_WIDTH-1:0]   value,
   output logic                     drop,
   output logic                     carry_out
);

   logic [ENTRY_WIDTH-1:0] value_ff;
   logic [ENTRY_WIDTH-1:0] value_in;
   logic                   drop_ff;
   logic                   drop_in;
   logic                   move;

   // A cell moves when it or any cell to its left is still marked, so each
   // step squeezes out the lowest marked entry.
   assign move = ctl.shift & (carry_in | drop_ff);

   // Next content of the cell.
   always_comb begin
      value_in = value_ff;
      drop_in  = drop_ff;
      if (ctl.mark) begin
         drop_in = mark;
      end else if (move) begin
         value_in = next_value;
         drop_in  = next_drop;
      end
      if (ctl.append && append_hit) begin
         value_in = append_value;
      end
   end

   // The mark is control state and resets; the entry itself does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= 1'b0;
      end else begin
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign drop      = drop_ff;
   assign carry_out = carry_in | drop_ff;

endmodule

[rtl/clst_checker.sv]
// Port-level checks for compacting_list_store_core, attached by bind.
// Depends on clst_pkg for field widths.
`timescale 1ns / 1ps

module clst_checker #(
   parameter int DEPTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_ok,
   input logic [clst_pkg::COUNT_OUT_W-1:0]  rsp_held_count,
   input logic [clst_pkg::VALUE_W-1:0]      rsp_read_value
);

   // The reported count never exceeds the list capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_held_count <= DEPTH))
      else $error("held count above capacity");

   // A failed operation, like any non-read, reports a zero read value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_read_value == '0))
      else $error("read value not zero on a failed operation");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok)
         && $stable(rsp_held_count) && $stable(rsp_read_value)))
      else $error("stalled response changed");

   // No response beat can appear in the cycle right after a request beat.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response appeared too early");

endmodule

bind compacting_list_store_core clst_checker #(
   .DEPTH (DEPTH)
) u_clst_checker (.*);

[sim/compacting_list_store_core_tb.sv]
// Self-checking testbench for compacting_list_store_core: drives request beats,
// predicts every response with a shadow copy of the list and compares field by field.
// Depends on clst_pkg and the RTL of compacting_list_store_core.
`timescale 1ns / 1ps

module compacting_list_store_core_tb;

   localparam int LIST_DEPTH      = 16;
   localparam int ITEMS_PER_PHASE = 332;
   localparam int QUIET_LIMIT     = 5000;
   localparam int TAIL_CYCLES     = 40;

   // One response beat as the shadow list expects it.
   typedef struct packed {
      logic                             ok;
      logic [clst_pkg::COUNT_OUT_W-1:0] held_count;
      logic [clst_pkg::VALUE_W-1:0]     read_value;
   } list_rsp_type;

   // Shadow copy of the list: it applies each accepted operation and queues the
   // response that the operation must produce.
   class list_shadow_type;
      logic [clst_pkg::VALUE_W-1:0] shadow_entries [LIST_DEPTH];
      int unsigned                  shadow_count;
      list_rsp_type                 expected_rsp [$];
      int unsigned                  answered;
      int unsigned                  mismatches;

      function new();
         foreach (shadow_entries[i]) shadow_entries[i] = '0;
         shadow_count = 0;
         answered = 0;
         mismatches = 0;
      endfunction

      function void note_request(input logic [clst_pkg::FUNC_W-1:0] op,
                                 input logic [clst_pkg::VALUE_W-1:0] value,
                                 input logic [clst_pkg::INDEX_W-1:0] first,
                                 input logic [clst_pkg::INDEX_W-1:0] last,
                                 input logic [clst_pkg::MASK_W-1:0] mask);
         bit           drop [LIST_DEPTH];
         list_rsp_type rsp;
         int unsigned  stop;
         int unsigned  keep;
         int unsigned  i;
         rsp = '0;
         foreach (drop[k]) drop[k] = 1'b0;
         case (op)
            clst_pkg::FUNC_APPEND: begin
               if (shadow_count < LIST_DEPTH) begin
                  shadow_entries[shadow_count] = value;
                  shadow_count++;
                  rsp.ok = 1'b1;
               end
            end
            clst_pkg::FUNC_REMOVE_AT: begin
               if (32'(first) < shadow_count) begin
                  drop[first] = 1'b1;
                  rsp.ok = 1'b1;
               end
            end
            clst_pkg::FUNC_REMOVE_SET: begin
               // Mask bits at or above the count select nothing.
               for (i = 0; i < clst_pkg::REACH && i < shadow_count; i++) begin
                  if (mask[i]) begin
                     drop[i] = 1'b1;
                     rsp.ok = 1'b1;
                  end
               end
            end
            clst_pkg::FUNC_REMOVE_RANGE: begin
               // The end is clipped to the tail; an end below the start drops nothing.
               if (32'(first) < shadow_count) begin
                  stop = 32'(last);
                  if (stop > shadow_count - 1) stop = shadow_count - 1;
                  for (i = 32'(first); i <= stop; i++) drop[i] = 1'b1;
                  rsp.ok = 1'b1;
               end
            end
            clst_pkg::FUNC_READ: begin
               if (32'(first) < shadow_count) begin
                  rsp.read_value = shadow_entries[first];
                  rsp.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         // Close the gaps left by dropped positions, keeping order.
         if (rsp.ok) begin
            keep = 0;
            for (i = 0; i < shadow_count; i++) begin
               if (!drop[i]) begin
                  shadow_entries[keep] = shadow_entries[i];
                  keep++;
               end
            end
            shadow_count = keep;
         end
         rsp.held_count = shadow_count[clst_pkg::COUNT_OUT_W-1:0];
         expected_rsp.push_back(rsp);
      endfunction

      function void check_response(input logic ok,
                                   input logic [clst_pkg::COUNT_OUT_W-1:0] held_count,
                                   input logic [clst_pkg::VALUE_W-1:0] read_value);
         list_rsp_type rsp;
         if (expected_rsp.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
            return;
         end
         rsp = expected_rsp.pop_front();
         answered++;
         if (ok !== rsp.ok) begin
            $error("ok: expected %0d, actual %0d", rsp.ok, ok);
            mismatches++;
         end
         if (held_count !== rsp.held_count) begin
            $error("held_count: expected %0d, actual %0d", rsp.held_count, held_count);
            mismatches++;
         end
         if (read_value !== rsp.read_value) begin
            $error("read_value: expected %h, actual %h", rsp.read_value, read_value);
            mismatches++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [clst_pkg::FUNC_W-1:0]      req_func = clst_pkg::FUNC_APPEND;
   logic [clst_pkg::VALUE_W-1:0]     req_entry_value = '0;
   logic [clst_pkg::INDEX_W-1:0]     req_first_index = '0;
   logic [clst_pkg::INDEX_W-1:0]     req_last_index = '0;
   logic [clst_pkg::MASK_W-1:0]      req_remove_mask = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_ok;
   logic [clst_pkg::COUNT_OUT_W-1:0] rsp_held_count;
   logic [clst_pkg::VALUE_W-1:0]     rsp_read_value;

   list_shadow_type shadow = new();
   int unsigned     issued = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     quiet_cycles = 0;

   compacting_list_store_core #(
      .DEPTH       (LIST_DEPTH),
      .ENTRY_WIDTH (clst_pkg::VALUE_W)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_entry_value (req_entry_value),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_remove_mask (req_remove_mask),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_held_count  (rsp_held_count),
      .rsp_read_value  (rsp_read_value)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Every accepted request beat feeds the shadow list; every response beat is checked.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         shadow.note_request(req_func, req_entry_value, req_first_index,
                             req_last_index, req_remove_mask);
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_response(rsp_ok, rsp_held_count, rsp_read_value);
   end

   // Watchdog: the run ends when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Present one request beat after a random idle gap and hold it until accepted.
   task automatic issue_op(input logic [clst_pkg::FUNC_W-1:0] op,
                           input logic [clst_pkg::VALUE_W-1:0] value,
                           input logic [clst_pkg::INDEX_W-1:0] first,
                           input logic [clst_pkg::INDEX_W-1:0] last,
                           input logic [clst_pkg::MASK_W-1:0] mask);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= op;
      req_entry_value <= value;
      req_first_index <= first;
      req_last_index  <= last;
      req_remove_mask <= mask;
      do @(posedge clock); while (!req_ready);
      issued++;
   endtask

   // Random operation, steered by the current count so that indexes mostly hit
   // held positions; the append share swings so the list fills and drains.
   task automatic issue_random_op();
      logic [clst_pkg::FUNC_W-1:0]  op;
      logic [clst_pkg::VALUE_W-1:0] value;
      logic [clst_pkg::INDEX_W-1:0] first;
      logic [clst_pkg::INDEX_W-1:0] last;
      logic [clst_pkg::MASK_W-1:0]  mask;
      int unsigned                  held;
      int unsigned                  top;
      int unsigned                  append_pct;
      int unsigned                  roll;
      held = shadow.shadow_count;
      top = (held == 0) ? 0 : held - 1;
      append_pct = (((issued / 60) % 2) == 0) ? 55 : 20;
      if ($urandom_range(0, 99) < append_pct) begin
         op = clst_pkg::FUNC_APPEND;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            op = clst_pkg::FUNC_READ + clst_pkg::FUNC_W'($urandom_range(1, 3));
         else if (roll < 30) op = clst_pkg::FUNC_READ;
         else if (roll < 50) op = clst_pkg::FUNC_REMOVE_AT;
         else if (roll < 72) op = clst_pkg::FUNC_REMOVE_SET;
         else                op = clst_pkg::FUNC_REMOVE_RANGE;
      end
      case ($urandom_range(0, 9))
         0:       value = '0;
         1:       value = '1;
         default: value = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) first = clst_pkg::INDEX_W'($urandom_range(0, 15));
      else                           first = clst_pkg::INDEX_W'($urandom_range(0, top));
      case ($urandom_range(0, 3))
         0:       last = clst_pkg::INDEX_W'($urandom_range(0, 15));
         1:       last = '1;
         default: last = (first + $urandom_range(0, 3) > 15) ? 4'hF
                         : first + clst_pkg::INDEX_W'($urandom_range(0, 3));
      endcase
      // Masks: a single held bit, sparse, only bits past the tail, or random.
      case ($urandom_range(0, 4))
         0:       mask = 16'h0001 << $urandom_range(0, top);
         1:       mask = clst_pkg::MASK_W'($urandom & $urandom);
         2:       mask = 16'hFFFF << held;
         default: mask = clst_pkg::MASK_W'($urandom);
      endcase
      issue_op(op, value, first, last, mask);
   endtask

   // Let every issued request be answered before going on.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (shadow.answered < issued) @(posedge clock);
   endtask

   initial begin
      int unsigned                  phase;
      logic [clst_pkg::VALUE_W-1:0] fill_value;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: operations on the empty list and undefined codes.
      issue_op(clst_pkg::FUNC_READ, '0, 4'd0, 4'd0, '0);
      issue_op(clst_pkg::FUNC_REMOVE_AT, '0, 4'd0, 4'd0, '0);
      issue_op(clst_pkg::FUNC_REMOVE_SET, '0, 4'd0, 4'd0, 16'hFFFF);
      issue_op(clst_pkg::FUNC_REMOVE_RANGE, '0, 4'd0, 4'd15, '0);
      issue_op(clst_pkg::FUNC_READ + clst_pkg::FUNC_W'(1), '1, 4'd15, 4'd15, 16'hFFFF);
      issue_op(clst_pkg::FUNC_READ + clst_pkg::FUNC_W'(3), '1, 4'd15, 4'd15, 16'hFFFF);
      // Fill the list with edge values, then append once more while full.
      for (int i = 0; i < LIST_DEPTH; i++) begin
         case (i)
            0:       fill_value = '0;
            1:       fill_value = '1;
            2:       fill_value = 32'hAAAA_AAAA;
            3:       fill_value = 32'h5555_5555;
            default: fill_value = $urandom;
         endcase
         issue_op(clst_pkg::FUNC_APPEND, fill_value, 4'd0, 4'd0, '0);
      end
      issue_op(clst_pkg::FUNC_APPEND, 32'hDEAD_BEEF, 4'd0, 4'd0, '0);
      issue_op(clst_pkg::FUNC_READ, '0, 4'd15, 4'd0, '0);
      // Range end below start removes nothing; an end at the tail removes through the last entry.
      issue_op(clst_pkg::FUNC_REMOVE_RANGE, '0, 4'd9, 4'd3, '0);
      issue_op(clst_pkg::FUNC_REMOVE_RANGE, '0, 4'd12, 4'd15, '0);
      wait_drained();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 66; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin send_idle_pct = 29; rsp_stall_pct = 29; end
         endcase
         repeat (ITEMS_PER_PHASE) issue_random_op();
         wait_drained();
      end

      // Quiet tail so that any stray response beat is still caught.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.expected_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
